### hdl/per_origin_packet_flag_counters_top_assert.svh
// Assertion macros shared by the counter block.
`ifndef PER_ORIGIN_PACKET_FLAG_COUNTERS_TOP_ASSERT_SVH
`define PER_ORIGIN_PACKET_FLAG_COUNTERS_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define POFC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define POFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/pofc_pkg.sv
// ----------------------------------------------------------------------------
// pofc_pkg
// Types, sizes and codes of the per-origin packet statistics block.
// ----------------------------------------------------------------------------
package pofc_pkg;

    localparam int unsigned MONITOR_SLOTS = 256;
    localparam int unsigned METRICS_SLOTS = 256;
    localparam int unsigned ORIGIN_CTRS   = 11;
    localparam int unsigned GLOBAL_CTRS   = 6;

    localparam int unsigned MON_AW = (MONITOR_SLOTS > 1) ? $clog2(MONITOR_SLOTS) : 1;
    localparam int unsigned MON_CW = $clog2(MONITOR_SLOTS + 1);
    localparam int unsigned MET_AW = (METRICS_SLOTS > 1) ? $clog2(METRICS_SLOTS) : 1;
    localparam int unsigned MET_CW = $clog2(METRICS_SLOTS + 1);
    localparam int unsigned CTR_DEPTH = METRICS_SLOTS * ORIGIN_CTRS;
    localparam int unsigned CTR_AW = $clog2(CTR_DEPTH);

    localparam logic [MON_CW-1:0] MON_LIM = MON_CW'(MONITOR_SLOTS);
    localparam logic [MET_CW-1:0] MET_LIM = MET_CW'(METRICS_SLOTS);

    // item kinds
    localparam logic [2:0] KIND_PKT   = 3'd0;
    localparam logic [2:0] KIND_REG   = 3'd1;
    localparam logic [2:0] KIND_UNREG = 3'd2;
    localparam logic [2:0] KIND_RDORG = 3'd3;
    localparam logic [2:0] KIND_RDGLB = 3'd4;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_SKIP     = 3'd1;
    localparam logic [2:0] ST_MET_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FND  = 3'd3;
    localparam logic [2:0] ST_MON_FULL = 3'd4;

    // origin counter selects
    localparam logic [3:0] C_PIN    = 4'd0;
    localparam logic [3:0] C_POUT   = 4'd1;
    localparam logic [3:0] C_BIN    = 4'd2;
    localparam logic [3:0] C_BOUT   = 4'd3;
    localparam logic [3:0] C_SYN    = 4'd4;
    localparam logic [3:0] C_SYNACK = 4'd5;
    localparam logic [3:0] C_FIN    = 4'd6;
    localparam logic [3:0] C_RST    = 4'd7;
    localparam logic [3:0] C_ACK    = 4'd8;
    localparam logic [3:0] C_DATA   = 4'd9;
    localparam logic [3:0] C_TIME   = 4'd10;

    // global counter selects
    localparam logic [2:0] G_PKTS   = 3'd0;
    localparam logic [2:0] G_BYTES  = 3'd1;
    localparam logic [2:0] G_SYN    = 3'd2;
    localparam logic [2:0] G_SYNACK = 3'd3;
    localparam logic [2:0] G_PASS   = 3'd4;
    localparam logic [2:0] G_TIME   = 3'd5;

    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  F_FIN = 8'h01;
    localparam logic [7:0]  F_SYN = 8'h02;
    localparam logic [7:0]  F_RST = 8'h04;
    localparam logic [7:0]  F_ACK = 8'h10;
    localparam logic [15:0] ETH_LEN      = 16'd14;
    localparam logic [15:0] MIN_IP_FRAME = 16'd34;
    localparam logic [15:0] DATA_LEN     = 16'd54;
    localparam logic [3:0]  MIN_IHL      = 4'd5;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [7:0]  flag_byte;
        logic [31:0] origin_address;
        logic [3:0]  counter_select;
        logic [63:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic        ingress_counted;
        logic        egress_counted;
    } t_out_word;

    // per-packet update context for the counter ALU
    typedef struct packed {
        logic        ingress;
        logic [7:0]  flags;
        logic [15:0] len;
        logic [63:0] now;
    } t_upd;

endpackage

### hdl/per_origin_packet_flag_counters_top.sv
// ----------------------------------------------------------------------------
// per_origin_packet_flag_counters_top
// Per-origin and global packet, byte and TCP flag statistics.
// ----------------------------------------------------------------------------
//  channel | valid      | stall       | word
//  --------+------------+-------------+------------------------------
//  input   | i_in_valid | o_in_stall  | i_in  (t_in_word)
//  output  | o_out_valid| i_out_stall | o_out (t_out_word)
//
// One word in flight. Every search walks its table one entry a cycle
// through the RAM read port: a monitor lookup walks all MONITOR_SLOTS
// entries, a metrics lookup at most the fill count, and each origin
// update reads then writes its 11 counters in turn on the counter RAM.
// Reset (synchronous) clears monitor valid bits, the metrics fill count
// and the global counters; no clearing pass is needed. Input stalls in reset.
// A finished result waits in the output register while output stalls.
module per_origin_packet_flag_counters_top
    import pofc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out
);
    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_DEC   = 12'b0000_0000_0010,
        S_MSCAN = 12'b0000_0000_0100,
        S_MUPD  = 12'b0000_0000_1000,
        S_KSCAN = 12'b0000_0001_0000,
        S_SLOT  = 12'b0000_0010_0000,
        S_CRD   = 12'b0000_0100_0000,
        S_CWR   = 12'b0000_1000_0000,
        S_GLOB  = 12'b0001_0000_0000,
        S_RDC   = 12'b0010_0000_0000,
        S_RDW   = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_in_word r_in;

    // monitor table: addresses in RAM, valid bits in flops
    logic [MONITOR_SLOTS-1:0] r_mon_v;
    logic [MON_CW-1:0] r_midx;
    logic [MON_AW-1:0] r_mpidx;
    logic              r_mpend;
    logic              r_ma_hit, r_mb_hit, r_free_hit;
    logic [MON_AW-1:0] r_ma_idx, r_free_idx;

    // metrics keys: slots fill in order and are never freed
    logic [MET_CW-1:0] r_met_cnt;
    logic [MET_CW-1:0] r_kidx;
    logic [MET_AW-1:0] r_kpidx;
    logic              r_kpend;
    logic              r_ka_hit, r_kb_hit;
    logic [MET_AW-1:0] r_ka_slot, r_kb_slot;

    // counter update sequencing
    logic              r_phase;  // 0 destination, 1 source
    logic [MET_AW-1:0] r_slot;
    logic [MET_AW-1:0] r_a_slot;
    logic              r_a_ok;
    logic              r_alloc;
    logic [3:0]        r_k;

    logic [2:0]  r_status;
    logic [63:0] r_value;
    logic        r_ing, r_egr;
    logic [63:0] r_glob [GLOBAL_CTRS];

    logic      r_out_valid;
    t_out_word r_out;

    // item decode
    logic        w_skip, w_tcp, w_syn, w_ack;
    logic [16:0] w_tcp_min;
    logic [7:0]  w_flags;
    logic [31:0] w_tgt_a;
    logic        w_out_free;
    logic        w_out_load;

    // RAM ports
    logic [31:0]       mon_rdata, key_rdata;
    logic [63:0]       ctr_rdata, ctr_wdata;
    logic              mon_we, key_we, ctr_we;
    logic [MON_AW-1:0] mon_waddr;
    logic [MET_AW-1:0] key_waddr;
    logic [31:0]       key_wdata;
    logic [CTR_AW-1:0] ctr_raddr, ctr_waddr;
    logic [MET_AW-1:0] ctr_slot;
    logic [3:0]        ctr_sel;
    t_upd              w_upd;

    // slot choice for the current update phase
    logic              w_want, w_hit, w_same;
    logic [MET_AW-1:0] w_hslot;

    assign w_tcp     = (r_in.ip_protocol == PROTO_TCP);
    assign w_tcp_min = 17'(ETH_LEN) + {11'd0, r_in.header_words, 2'b00} + 17'd20;
    assign w_skip    = (r_in.frame_length < ETH_LEN) || (r_in.ether_type != ETYPE_IPV4) ||
                       (r_in.frame_length < MIN_IP_FRAME) || (r_in.header_words < MIN_IHL) ||
                       (w_tcp && ({1'b0, r_in.frame_length} < w_tcp_min));
    assign w_flags   = w_tcp ? r_in.flag_byte : 8'd0;
    assign w_syn     = |(w_flags & F_SYN);
    assign w_ack     = |(w_flags & F_ACK);
    assign w_tgt_a   = (r_in.kind == KIND_PKT) ? r_in.dest_address : r_in.origin_address;

    assign w_want  = r_phase ? r_mb_hit : r_ma_hit;
    assign w_hit   = r_phase ? r_kb_hit : r_ka_hit;
    assign w_hslot = r_phase ? r_kb_slot : r_ka_slot;
    assign w_same  = r_phase && (r_in.source_address == r_in.dest_address);

    assign w_upd = '{ingress: !r_phase, flags: w_flags, len: r_in.frame_length,
                     now: r_in.timestamp};

    // RAM control
    assign mon_we    = (r_state == S_MUPD) && (r_in.kind == KIND_REG) && !r_ma_hit &&
                       r_free_hit;
    assign mon_waddr = r_free_idx;
    assign key_we    = (r_state == S_SLOT) && w_want && !w_same && !w_hit &&
                       (r_met_cnt < MET_LIM);
    assign key_waddr = r_met_cnt[MET_AW-1:0];
    assign key_wdata = r_phase ? r_in.source_address : r_in.dest_address;
    assign ctr_slot  = (r_state == S_RDC) ? r_ka_slot : r_slot;
    assign ctr_sel   = (r_state == S_RDC) ? r_in.counter_select : r_k;
    assign ctr_raddr = CTR_AW'(ctr_slot) * CTR_AW'(ORIGIN_CTRS) + CTR_AW'(ctr_sel);
    assign ctr_waddr = CTR_AW'(r_slot) * CTR_AW'(ORIGIN_CTRS) + CTR_AW'(r_k);
    assign ctr_we    = (r_state == S_CWR);

    pofc_ram #(.W(32), .D(MONITOR_SLOTS), .AW(MON_AW)) u_mon_ram (
        .i_clk  (i_clk),
        .i_we   (mon_we),
        .i_waddr(mon_waddr),
        .i_wdata(r_in.origin_address),
        .i_raddr(r_midx[MON_AW-1:0]),
        .o_rdata(mon_rdata)
    );

    pofc_ram #(.W(32), .D(METRICS_SLOTS), .AW(MET_AW)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(key_waddr),
        .i_wdata(key_wdata),
        .i_raddr(r_kidx[MET_AW-1:0]),
        .o_rdata(key_rdata)
    );

    pofc_ram #(.W(64), .D(CTR_DEPTH), .AW(CTR_AW)) u_ctr_ram (
        .i_clk  (i_clk),
        .i_we   (ctr_we),
        .i_waddr(ctr_waddr),
        .i_wdata(ctr_wdata),
        .i_raddr(ctr_raddr),
        .o_rdata(ctr_rdata)
    );

    // fresh slot starts from zero instead of undefined RAM contents
    pofc_ctr_alu u_alu (
        .i_sel(r_k),
        .i_old(r_alloc ? 64'd0 : ctr_rdata),
        .i_upd(w_upd),
        .o_new(ctr_wdata)
    );

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mon_v     <= '0;
            r_met_cnt   <= '0;
            r_out_valid <= 1'b0;
            for (int g = 0; g < GLOBAL_CTRS; g++) begin
                r_glob[g] <= 64'd0;
            end
        end else begin
            // output register: load a finished word or retire an accepted one
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_in       <= i_in;
                        r_status   <= ST_OK;
                        r_value    <= 64'd0;
                        r_ing      <= 1'b0;
                        r_egr      <= 1'b0;
                        r_phase    <= 1'b0;
                        r_a_ok     <= 1'b0;
                        r_midx     <= '0;
                        r_mpend    <= 1'b0;
                        r_ma_hit   <= 1'b0;
                        r_mb_hit   <= 1'b0;
                        r_free_hit <= 1'b0;
                        r_kidx     <= '0;
                        r_kpend    <= 1'b0;
                        r_ka_hit   <= 1'b0;
                        r_kb_hit   <= 1'b0;
                        r_state    <= S_DEC;
                    end
                end
                S_DEC: begin
                    case (r_in.kind)
                        KIND_PKT: begin
                            if (w_skip) begin
                                r_status <= ST_SKIP;
                                r_state  <= S_DONE;
                            end else begin
                                r_state <= S_MSCAN;
                            end
                        end
                        KIND_REG, KIND_UNREG: r_state <= S_MSCAN;
                        KIND_RDORG:           r_state <= S_KSCAN;
                        KIND_RDGLB: begin
                            if (r_in.counter_select < 4'(GLOBAL_CTRS)) begin
                                r_value <= r_glob[r_in.counter_select[2:0]];
                            end
                            r_state <= S_DONE;
                        end
                        default: begin
                            r_status <= ST_SKIP;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_MSCAN: begin
                    // compare the entry read last cycle
                    if (r_mpend) begin
                        if (r_mon_v[r_mpidx] && mon_rdata == w_tgt_a && !r_ma_hit) begin
                            r_ma_hit <= 1'b1;
                            r_ma_idx <= r_mpidx;
                        end
                        if (r_mon_v[r_mpidx] && mon_rdata == r_in.source_address &&
                            r_in.kind == KIND_PKT) begin
                            r_mb_hit <= 1'b1;
                        end
                        if (!r_mon_v[r_mpidx] && !r_free_hit) begin
                            r_free_hit <= 1'b1;
                            r_free_idx <= r_mpidx;
                        end
                    end
                    if (r_midx < MON_LIM) begin
                        r_mpend <= 1'b1;
                        r_mpidx <= r_midx[MON_AW-1:0];
                        r_midx  <= r_midx + 1'b1;
                    end else begin
                        r_mpend <= 1'b0;
                    end
                    if (!r_mpend && r_midx == MON_LIM) begin
                        if (r_in.kind == KIND_PKT) begin
                            r_state <= (r_ma_hit || r_mb_hit) ? S_KSCAN : S_GLOB;
                        end else begin
                            r_state <= S_MUPD;
                        end
                    end
                end
                S_MUPD: begin
                    if (r_in.kind == KIND_REG) begin
                        if (!r_ma_hit) begin
                            if (r_free_hit) begin
                                r_mon_v[r_free_idx] <= 1'b1;
                            end else begin
                                r_status <= ST_MON_FULL;
                            end
                        end
                    end else begin
                        if (r_ma_hit) begin
                            r_mon_v[r_ma_idx] <= 1'b0;
                        end else begin
                            r_status <= ST_NOT_FND;
                        end
                    end
                    r_state <= S_DONE;
                end
                S_KSCAN: begin
                    if (r_kpend) begin
                        if (key_rdata == w_tgt_a && !r_ka_hit) begin
                            r_ka_hit  <= 1'b1;
                            r_ka_slot <= r_kpidx;
                        end
                        if (key_rdata == r_in.source_address && !r_kb_hit) begin
                            r_kb_hit  <= 1'b1;
                            r_kb_slot <= r_kpidx;
                        end
                    end
                    if (r_kidx < r_met_cnt) begin
                        r_kpend <= 1'b1;
                        r_kpidx <= r_kidx[MET_AW-1:0];
                        r_kidx  <= r_kidx + 1'b1;
                    end else begin
                        r_kpend <= 1'b0;
                    end
                    if (!r_kpend && r_kidx == r_met_cnt) begin
                        if (r_in.kind == KIND_PKT) begin
                            r_state <= S_SLOT;
                        end else if (!r_ka_hit) begin
                            r_status <= ST_NOT_FND;
                            r_state  <= S_DONE;
                        end else if (r_in.counter_select < 4'(ORIGIN_CTRS)) begin
                            r_state <= S_RDC;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SLOT: begin
                    r_k <= C_PIN;
                    if (!w_want) begin
                        r_phase <= 1'b1;
                        r_state <= r_phase ? S_GLOB : S_SLOT;
                    end else if (w_same && r_a_ok) begin
                        // source equals destination: reuse its slot
                        r_slot  <= r_a_slot;
                        r_alloc <= 1'b0;
                        r_egr   <= 1'b1;
                        r_state <= S_CRD;
                    end else if (!w_same && w_hit) begin
                        r_slot  <= w_hslot;
                        r_alloc <= 1'b0;
                        r_state <= S_CRD;
                        if (r_phase) begin
                            r_egr <= 1'b1;
                        end else begin
                            r_ing    <= 1'b1;
                            r_a_ok   <= 1'b1;
                            r_a_slot <= w_hslot;
                        end
                    end else if (!w_same && r_met_cnt < MET_LIM) begin
                        r_slot    <= r_met_cnt[MET_AW-1:0];
                        r_alloc   <= 1'b1;
                        r_met_cnt <= r_met_cnt + 1'b1;
                        r_state   <= S_CRD;
                        if (r_phase) begin
                            r_egr <= 1'b1;
                        end else begin
                            r_ing    <= 1'b1;
                            r_a_ok   <= 1'b1;
                            r_a_slot <= r_met_cnt[MET_AW-1:0];
                        end
                    end else begin
                        r_status <= ST_MET_FULL;
                        r_phase  <= 1'b1;
                        r_state  <= r_phase ? S_GLOB : S_SLOT;
                    end
                end
                S_CRD: r_state <= S_CWR;
                S_CWR: begin
                    if (r_k == C_TIME) begin
                        r_phase <= 1'b1;
                        r_state <= r_phase ? S_GLOB : S_SLOT;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_CRD;
                    end
                end
                S_GLOB: begin
                    r_glob[G_PKTS]  <= r_glob[G_PKTS] + 64'd1;
                    r_glob[G_BYTES] <= r_glob[G_BYTES] + {48'd0, r_in.frame_length};
                    if (w_syn && !w_ack) begin
                        r_glob[G_SYN] <= r_glob[G_SYN] + 64'd1;
                    end
                    if (w_syn && w_ack) begin
                        r_glob[G_SYNACK] <= r_glob[G_SYNACK] + 64'd1;
                    end
                    r_glob[G_PASS] <= r_glob[G_PASS] + 64'd1;
                    r_glob[G_TIME] <= r_in.timestamp;
                    r_state <= S_DONE;
                end
                S_RDC: r_state <= S_RDW;
                S_RDW: begin
                    r_value <= ctr_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out   <= '{status: r_status, read_value: r_value,
                                     ingress_counted: r_ing, egress_counted: r_egr};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`include "per_origin_packet_flag_counters_top_assert.svh"

    `POFC_ASSERT_NOW(a_fill_bound, 1'b1, r_met_cnt <= MET_LIM, "metrics fill count overran")
    `POFC_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, r_state == S_DEC,
                      "accepted word not decoded")
    `POFC_ASSERT_NOW(a_skip_uncounted, o_out_valid && o_out.status == ST_SKIP,
                     !o_out.ingress_counted && !o_out.egress_counted,
                     "skipped packet marked as counted")
    `POFC_ASSERT_NOW(a_ctr_sel_range, r_state == S_CWR, r_k <= C_TIME,
                     "counter index out of range")

endmodule

### hdl/pofc_ram.sv
// ----------------------------------------------------------------------------
// pofc_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pofc_ram #(
    parameter int unsigned W  = 32,
    parameter int unsigned D  = 256,
    parameter int unsigned AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/pofc_ctr_alu.sv
// ----------------------------------------------------------------------------
// pofc_ctr_alu
// Next value of one origin counter for a counted packet.
// ----------------------------------------------------------------------------
module pofc_ctr_alu
    import pofc_pkg::*;
(
    input  logic [3:0]  i_sel,
    input  logic [63:0] i_old,
    input  t_upd        i_upd,
    output logic [63:0] o_new
);
    logic        syn, ack;
    logic [63:0] inc;

    assign syn = |(i_upd.flags & F_SYN);
    assign ack = |(i_upd.flags & F_ACK);

    always_comb begin
        inc = 64'd0;
        case (i_sel)
            C_PIN:    inc = {63'd0, i_upd.ingress};
            C_POUT:   inc = {63'd0, !i_upd.ingress};
            C_BIN:    inc = i_upd.ingress ? {48'd0, i_upd.len} : 64'd0;
            C_BOUT:   inc = i_upd.ingress ? 64'd0 : {48'd0, i_upd.len};
            C_SYN:    inc = {63'd0, syn && !ack};
            C_SYNACK: inc = {63'd0, syn && ack};
            C_FIN:    inc = {63'd0, |(i_upd.flags & F_FIN)};
            C_RST:    inc = {63'd0, |(i_upd.flags & F_RST)};
            C_ACK:    inc = {63'd0, ack && !syn};
            C_DATA:   inc = {63'd0, i_upd.len > DATA_LEN};
            default:  inc = 64'd0;
        endcase
    end

    assign o_new = (i_sel == C_TIME) ? i_upd.now : i_old + inc;
endmodule
